FILE: hw/rtl/igrl_pkg.sv
// Shared types, constants and helpers for the pan-tilt visual-servo rate law.
// Used by igrl_alu, igrl_div and ibvs_gimbal_rate_law_top. No dependencies.
package igrl_pkg;

  // Fixed-point format
  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;
  localparam int DIV_NW    = DW + FRAC_BITS + 1;

  localparam logic signed [DW-1:0] Q_ONE = DW'(1) << FRAC_BITS;
  localparam logic signed [DW-1:0] Q_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] Q_MIN = {1'b1, {(DW-1){1'b0}}};

  // Configuration register indexes
  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_GAIN   = 3'd1;
  localparam logic [2:0] REG_MAX    = 3'd2;
  localparam logic [2:0] REG_DEAD   = 3'd3;
  localparam logic [2:0] REG_TGT_X  = 3'd4;
  localparam logic [2:0] REG_TGT_Y  = 3'd5;

  // Tracking modes
  localparam logic [1:0] MODE_LOCK   = 2'd0;
  localparam logic [1:0] MODE_NORMAL = 2'd1;
  localparam logic [1:0] MODE_MINUS  = 2'd2;

  // Limiter status codes
  localparam logic [1:0] LIM_PASS  = 2'd0;
  localparam logic [1:0] LIM_CLAMP = 2'd1;
  localparam logic [1:0] LIM_DEAD  = 2'd2;

  // Shared unit operations
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_NEG = 3'd2;
  localparam logic [2:0] OP_MUL = 3'd3;
  localparam logic [2:0] OP_DIV = 3'd4;

  // Operand sources
  localparam logic [4:0] S_X    = 5'd0;
  localparam logic [4:0] S_Y    = 5'd1;
  localparam logic [4:0] S_Z    = 5'd2;
  localparam logic [4:0] S_PX   = 5'd3;
  localparam logic [4:0] S_PY   = 5'd4;
  localparam logic [4:0] S_PZ   = 5'd5;
  localparam logic [4:0] S_MV0  = 5'd6;
  localparam logic [4:0] S_MV1  = 5'd7;
  localparam logic [4:0] S_MV2  = 5'd8;
  localparam logic [4:0] S_MV3  = 5'd9;
  localparam logic [4:0] S_MV4  = 5'd10;
  localparam logic [4:0] S_MV5  = 5'd11;
  localparam logic [4:0] S_TILT = 5'd12;
  localparam logic [4:0] S_ONE  = 5'd13;
  localparam logic [4:0] S_T    = 5'd14;
  localparam logic [4:0] S_U0   = 5'd15;
  localparam logic [4:0] S_U1   = 5'd16;
  localparam logic [4:0] S_XX   = 5'd17;
  localparam logic [4:0] S_YY   = 5'd18;
  localparam logic [4:0] S_XY   = 5'd19;
  localparam logic [4:0] S_OPX  = 5'd20;
  localparam logic [4:0] S_OPY  = 5'd21;
  localparam logic [4:0] S_YPZ  = 5'd22;
  localparam logic [4:0] S_PXZ  = 5'd23;
  localparam logic [4:0] S_PYZ  = 5'd24;
  localparam logic [4:0] S_A0   = 5'd25;
  localparam logic [4:0] S_A1   = 5'd26;
  localparam logic [4:0] S_DET  = 5'd27;
  localparam logic [4:0] S_C1   = 5'd28;
  localparam logic [4:0] S_GAIN = 5'd29;
  localparam logic [4:0] S_TX   = 5'd30;
  localparam logic [4:0] S_TY   = 5'd31;

  // Result destinations
  localparam logic [4:0] D_T     = 5'd0;
  localparam logic [4:0] D_U0    = 5'd1;
  localparam logic [4:0] D_U1    = 5'd2;
  localparam logic [4:0] D_XX    = 5'd3;
  localparam logic [4:0] D_YY    = 5'd4;
  localparam logic [4:0] D_XY    = 5'd5;
  localparam logic [4:0] D_OPX   = 5'd6;
  localparam logic [4:0] D_OPY   = 5'd7;
  localparam logic [4:0] D_YPZ   = 5'd8;
  localparam logic [4:0] D_PXZ   = 5'd9;
  localparam logic [4:0] D_PYZ   = 5'd10;
  localparam logic [4:0] D_A0    = 5'd11;
  localparam logic [4:0] D_A1    = 5'd12;
  localparam logic [4:0] D_DET   = 5'd13;
  localparam logic [4:0] D_C1    = 5'd14;
  localparam logic [4:0] D_PITCH = 5'd15;
  localparam logic [4:0] D_YAW   = 5'd16;

  // Program addresses where the sequencer branches
  localparam logic [6:0] PC_GAIN = 7'd44;
  localparam logic [6:0] PC_ADJ  = 7'd50;
  localparam logic [6:0] PC_OUT  = 7'd64;

  typedef struct packed {
    logic [2:0] op;
    logic [4:0] src_a;
    logic [4:0] src_b;
    logic [4:0] dst;
  } uop_t;

  typedef struct packed {
    logic signed [DW-1:0] val;
    logic [1:0]           code;
  } lim_t;

  // Saturate a 33-bit sum to 32 bits
  function automatic logic signed [DW-1:0] sat33(input logic signed [DW:0] v);
    if (v > $signed({1'b0, Q_MAX})) begin
      return Q_MAX;
    end else if (v < $signed({1'b1, Q_MIN})) begin
      return Q_MIN;
    end
    return v[DW-1:0];
  endfunction

  // Clamp to max, then zero below the dead zone
  function automatic lim_t limit_rate(input logic signed [DW-1:0] v,
                                      input logic [DW-2:0] max_r,
                                      input logic [DW-2:0] dead);
    lim_t r;
    logic [DW-1:0] mag;
    mag    = v[DW-1] ? DW'(-v) : DW'(v);
    r.val  = v;
    r.code = LIM_PASS;
    if (mag > {1'b0, max_r}) begin
      r.val  = v[DW-1] ? -$signed({1'b0, max_r}) : $signed({1'b0, max_r});
      mag    = {1'b0, max_r};
      r.code = LIM_CLAMP;
    end
    if (mag < {1'b0, dead}) begin
      r.val  = '0;
      r.code = LIM_DEAD;
    end
    return r;
  endfunction

  // Micro-program of the rate law, one ALU or divider operation per address
  function automatic uop_t micro_rom(input logic [6:0] pc);
    uop_t u;
    case (pc)
      7'd0:  u = '{OP_MUL, S_X,    S_X,    D_XX};
      7'd1:  u = '{OP_MUL, S_Y,    S_Y,    D_YY};
      7'd2:  u = '{OP_MUL, S_X,    S_Y,    D_XY};
      7'd3:  u = '{OP_MUL, S_PY,   S_Z,    D_PYZ};
      7'd4:  u = '{OP_MUL, S_PX,   S_Z,    D_PXZ};
      7'd5:  u = '{OP_ADD, S_ONE,  S_XX,   D_OPX};
      7'd6:  u = '{OP_ADD, S_ONE,  S_YY,   D_OPY};
      7'd7:  u = '{OP_NEG, S_Z,    S_Z,    D_T};
      7'd8:  u = '{OP_MUL, S_T,    S_MV0,  D_U0};
      7'd9:  u = '{OP_MUL, S_T,    S_MV1,  D_U1};
      7'd10: u = '{OP_MUL, S_X,    S_Z,    D_T};
      7'd11: u = '{OP_MUL, S_T,    S_MV2,  D_T};
      7'd12: u = '{OP_ADD, S_U0,   S_T,    D_U0};
      7'd13: u = '{OP_MUL, S_Y,    S_Z,    D_T};
      7'd14: u = '{OP_MUL, S_T,    S_MV2,  D_T};
      7'd15: u = '{OP_ADD, S_U1,   S_T,    D_U1};
      7'd16: u = '{OP_ADD, S_Y,    S_PYZ,  D_YPZ};
      7'd17: u = '{OP_MUL, S_X,    S_YPZ,  D_T};
      7'd18: u = '{OP_MUL, S_T,    S_MV3,  D_T};
      7'd19: u = '{OP_ADD, S_U0,   S_T,    D_U0};
      7'd20: u = '{OP_MUL, S_PY,   S_Y,    D_T};
      7'd21: u = '{OP_ADD, S_PZ,   S_T,    D_T};
      7'd22: u = '{OP_MUL, S_Z,    S_T,    D_T};
      7'd23: u = '{OP_ADD, S_OPY,  S_T,    D_T};
      7'd24: u = '{OP_MUL, S_T,    S_MV3,  D_T};
      7'd25: u = '{OP_ADD, S_U1,   S_T,    D_U1};
      7'd26: u = '{OP_MUL, S_PX,   S_X,    D_T};
      7'd27: u = '{OP_ADD, S_PZ,   S_T,    D_T};
      7'd28: u = '{OP_MUL, S_Z,    S_T,    D_T};
      7'd29: u = '{OP_ADD, S_OPX,  S_T,    D_T};
      7'd30: u = '{OP_NEG, S_T,    S_T,    D_T};
      7'd31: u = '{OP_MUL, S_T,    S_MV4,  D_T};
      7'd32: u = '{OP_ADD, S_U0,   S_T,    D_U0};
      7'd33: u = '{OP_ADD, S_X,    S_PXZ,  D_T};
      7'd34: u = '{OP_MUL, S_Y,    S_T,    D_T};
      7'd35: u = '{OP_NEG, S_T,    S_T,    D_T};
      7'd36: u = '{OP_MUL, S_T,    S_MV4,  D_T};
      7'd37: u = '{OP_ADD, S_U1,   S_T,    D_U1};
      7'd38: u = '{OP_MUL, S_YPZ,  S_MV5,  D_T};
      7'd39: u = '{OP_ADD, S_U0,   S_T,    D_U0};
      7'd40: u = '{OP_NEG, S_X,    S_X,    D_T};
      7'd41: u = '{OP_SUB, S_T,    S_PXZ,  D_T};
      7'd42: u = '{OP_MUL, S_T,    S_MV5,  D_T};
      7'd43: u = '{OP_ADD, S_U1,   S_T,    D_U1};
      7'd44: u = '{OP_SUB, S_X,    S_TX,   D_T};
      7'd45: u = '{OP_MUL, S_GAIN, S_T,    D_T};
      7'd46: u = '{OP_ADD, S_U0,   S_T,    D_U0};
      7'd47: u = '{OP_SUB, S_Y,    S_TY,   D_T};
      7'd48: u = '{OP_MUL, S_GAIN, S_T,    D_T};
      7'd49: u = '{OP_ADD, S_U1,   S_T,    D_U1};
      7'd50: u = '{OP_NEG, S_XY,   S_XY,   D_T};
      7'd51: u = '{OP_MUL, S_T,    S_U0,   D_A0};
      7'd52: u = '{OP_MUL, S_OPX,  S_U1,   D_T};
      7'd53: u = '{OP_ADD, S_A0,   S_T,    D_A0};
      7'd54: u = '{OP_NEG, S_OPY,  S_OPY,  D_T};
      7'd55: u = '{OP_MUL, S_T,    S_U0,   D_A1};
      7'd56: u = '{OP_MUL, S_XY,   S_U1,   D_T};
      7'd57: u = '{OP_ADD, S_A1,   S_T,    D_A1};
      7'd58: u = '{OP_ADD, S_OPX,  S_YY,   D_DET};
      7'd59: u = '{OP_DIV, S_A0,   S_DET,  D_T};
      7'd60: u = '{OP_NEG, S_T,    S_T,    D_PITCH};
      7'd61: u = '{OP_DIV, S_A1,   S_DET,  D_T};
      7'd62: u = '{OP_NEG, S_T,    S_T,    D_C1};
      7'd63: u = '{OP_DIV, S_C1,   S_TILT, D_YAW};
      default: u = '{OP_ADD, S_T,  S_T,    D_T};
    endcase
    return u;
  endfunction

endpackage

FILE: hw/rtl/ibvs_gimbal_rate_law_top.sv
// Top level of the pan-tilt visual-servo rate law: sequencer, operand
// registers, limiter and ports. Depends on igrl_pkg, igrl_alu, igrl_div.
//
// A kind-0 transaction (motion and tilt cosine) is stored and yields no
// result. A kind-1 transaction runs a 64-step micro-program on one shared
// add/multiply unit and one bit-serial divider; minus mode skips the gain
// steps and lock mode goes straight to the output step. Each of the three
// divisions holds the sequencer through start, 49 quotient bits, sign and
// write-back, or through start and write-back for a zero divisor such as a
// zero tilt cosine. Delivery also waits while the previous result is unread.
// in_ready is low while an item is being worked; a finished result waits in
// the output register and the next item may be accepted meanwhile.
// Configuration writes are taken every cycle.
module ibvs_gimbal_rate_law_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic signed [31:0] word_a,
  input  logic signed [31:0] word_b,
  input  logic signed [31:0] word_c,
  input  logic signed [31:0] word_d,
  input  logic signed [31:0] word_e,
  input  logic signed [31:0] word_f,
  input  logic signed [17:0] word_g,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pitch_rate,
  output logic signed [31:0] yaw_rate,
  output logic [1:0]         pitch_limit,
  output logic [1:0]         yaw_limit
);

  localparam int DW = igrl_pkg::DW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0] state;
  logic [6:0] pc;
  igrl_pkg::uop_t uop;

  // configuration
  logic [1:0]           track_mode;
  logic [DW-2:0]        error_gain;
  logic [DW-2:0]        max_rate;
  logic [DW-2:0]        dead_zone;
  logic signed [DW-1:0] target_x;
  logic signed [DW-1:0] target_y;

  // stored motion and tilt
  logic signed [DW-1:0] mv0, mv1, mv2, mv3, mv4, mv5;
  logic signed [17:0]   tilt;

  // latched features and working registers
  logic signed [DW-1:0] fx, fy, fz, fpx, fpy, fpz;
  logic signed [DW-1:0] t, u0, u1, xx, yy, xy, opx, opy, ypz, pxz, pyz;
  logic signed [DW-1:0] a0, a1, det, c1, pitch, yaw;

  logic signed [DW-1:0] opa, opb, alu_y, div_res, wr_data;
  logic                 div_start, div_done, wr_en, skip_gain;
  logic [4:0]           wr_dst;
  igrl_pkg::lim_t       lim_p, lim_y;

  function automatic logic signed [DW-1:0] pick(input logic [4:0] s);
    case (s)
      igrl_pkg::S_X:    return fx;
      igrl_pkg::S_Y:    return fy;
      igrl_pkg::S_Z:    return fz;
      igrl_pkg::S_PX:   return fpx;
      igrl_pkg::S_PY:   return fpy;
      igrl_pkg::S_PZ:   return fpz;
      igrl_pkg::S_MV0:  return mv0;
      igrl_pkg::S_MV1:  return mv1;
      igrl_pkg::S_MV2:  return mv2;
      igrl_pkg::S_MV3:  return mv3;
      igrl_pkg::S_MV4:  return mv4;
      igrl_pkg::S_MV5:  return mv5;
      igrl_pkg::S_TILT: return DW'(tilt);
      igrl_pkg::S_ONE:  return igrl_pkg::Q_ONE;
      igrl_pkg::S_T:    return t;
      igrl_pkg::S_U0:   return u0;
      igrl_pkg::S_U1:   return u1;
      igrl_pkg::S_XX:   return xx;
      igrl_pkg::S_YY:   return yy;
      igrl_pkg::S_XY:   return xy;
      igrl_pkg::S_OPX:  return opx;
      igrl_pkg::S_OPY:  return opy;
      igrl_pkg::S_YPZ:  return ypz;
      igrl_pkg::S_PXZ:  return pxz;
      igrl_pkg::S_PYZ:  return pyz;
      igrl_pkg::S_A0:   return a0;
      igrl_pkg::S_A1:   return a1;
      igrl_pkg::S_DET:  return det;
      igrl_pkg::S_C1:   return c1;
      igrl_pkg::S_GAIN: return {1'b0, error_gain};
      igrl_pkg::S_TX:   return target_x;
      igrl_pkg::S_TY:   return target_y;
      default:          return '0;
    endcase
  endfunction

  // Decode the current step
  assign uop       = igrl_pkg::micro_rom(pc);
  always_comb begin
    opa = pick(uop.src_a);
    opb = pick(uop.src_b);
  end
  assign skip_gain = (pc == igrl_pkg::PC_GAIN) && (track_mode != igrl_pkg::MODE_NORMAL);
  assign div_start = (state == ST_RUN) && (pc != igrl_pkg::PC_OUT) && !skip_gain &&
                     (uop.op == igrl_pkg::OP_DIV);

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);

  igrl_alu u_alu (
    .op (uop.op),
    .a  (opa),
    .b  (opb),
    .y  (alu_y)
  );

  igrl_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .a     (opa),
    .b     (opb),
    .done  (div_done),
    .res   (div_res)
  );

  // Select the write-back for this cycle
  always_comb begin
    wr_en   = 1'b0;
    wr_data = alu_y;
    wr_dst  = uop.dst;
    if (state == ST_WAIT) begin
      wr_en   = div_done;
      wr_data = div_res;
    end else if (state == ST_RUN && pc != igrl_pkg::PC_OUT && !skip_gain &&
                 uop.op != igrl_pkg::OP_DIV) begin
      wr_en = 1'b1;
    end
  end

  // Limit both rates at the output step
  assign lim_p = igrl_pkg::limit_rate(pitch, max_rate, dead_zone);
  assign lim_y = igrl_pkg::limit_rate(yaw, max_rate, dead_zone);

  // Working registers; lock mode clears pitch and yaw at acceptance
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && kind && track_mode != igrl_pkg::MODE_NORMAL &&
        track_mode != igrl_pkg::MODE_MINUS) begin
      pitch <= '0;
      yaw   <= '0;
    end else if (wr_en) begin
      case (wr_dst)
        igrl_pkg::D_T:     t     <= wr_data;
        igrl_pkg::D_U0:    u0    <= wr_data;
        igrl_pkg::D_U1:    u1    <= wr_data;
        igrl_pkg::D_XX:    xx    <= wr_data;
        igrl_pkg::D_YY:    yy    <= wr_data;
        igrl_pkg::D_XY:    xy    <= wr_data;
        igrl_pkg::D_OPX:   opx   <= wr_data;
        igrl_pkg::D_OPY:   opy   <= wr_data;
        igrl_pkg::D_YPZ:   ypz   <= wr_data;
        igrl_pkg::D_PXZ:   pxz   <= wr_data;
        igrl_pkg::D_PYZ:   pyz   <= wr_data;
        igrl_pkg::D_A0:    a0    <= wr_data;
        igrl_pkg::D_A1:    a1    <= wr_data;
        igrl_pkg::D_DET:   det   <= wr_data;
        igrl_pkg::D_C1:    c1    <= wr_data;
        igrl_pkg::D_PITCH: pitch <= wr_data;
        igrl_pkg::D_YAW:   yaw   <= wr_data;
        default: ;
      endcase
    end
  end

  // Latch features of a kind-1 transaction
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && kind) begin
      fx  <= word_a;
      fy  <= word_b;
      fz  <= word_c;
      fpx <= word_d;
      fpy <= word_e;
      fpz <= word_f;
    end
  end

  // Configuration, stored motion, sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pc         <= '0;
      out_valid  <= 1'b0;
      track_mode <= igrl_pkg::MODE_LOCK;
      error_gain <= (DW-1)'(igrl_pkg::Q_ONE);
      max_rate   <= (DW-1)'(igrl_pkg::Q_ONE);
      dead_zone  <= '0;
      target_x   <= '0;
      target_y   <= '0;
      mv0        <= '0;
      mv1        <= '0;
      mv2        <= '0;
      mv3        <= '0;
      mv4        <= '0;
      mv5        <= '0;
      tilt       <= 18'(igrl_pkg::Q_ONE);
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          igrl_pkg::REG_MODE:  track_mode <= cfg_data[1:0];
          igrl_pkg::REG_GAIN:  error_gain <= cfg_data[DW-2:0];
          igrl_pkg::REG_MAX:   max_rate   <= cfg_data[DW-2:0];
          igrl_pkg::REG_DEAD:  dead_zone  <= cfg_data[DW-2:0];
          igrl_pkg::REG_TGT_X: target_x   <= cfg_data;
          igrl_pkg::REG_TGT_Y: target_y   <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (!kind) begin
              mv0  <= word_a;
              mv1  <= word_b;
              mv2  <= word_c;
              mv3  <= word_d;
              mv4  <= word_e;
              mv5  <= word_f;
              tilt <= word_g;
            end else begin
              state <= ST_RUN;
              if (track_mode == igrl_pkg::MODE_NORMAL ||
                  track_mode == igrl_pkg::MODE_MINUS) begin
                pc <= '0;
              end else begin
                pc <= igrl_pkg::PC_OUT;
              end
            end
          end
        end
        ST_RUN: begin
          if (pc == igrl_pkg::PC_OUT) begin
            // deliver once the output register is free
            if (!out_valid || out_ready) begin
              pitch_rate  <= lim_p.val;
              pitch_limit <= lim_p.code;
              yaw_rate    <= lim_y.val;
              yaw_limit   <= lim_y.code;
              out_valid   <= 1'b1;
              state       <= ST_IDLE;
            end
          end else if (skip_gain) begin
            pc <= igrl_pkg::PC_ADJ;
          end else if (uop.op == igrl_pkg::OP_DIV) begin
            state <= ST_WAIT;
          end else begin
            pc <= pc + 1'b1;
          end
        end
        ST_WAIT: begin
          if (div_done) begin
            pc    <= pc + 1'b1;
            state <= ST_RUN;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/igrl_alu.sv
// Shared combinational arithmetic unit: saturating add, subtract, negate and
// rounded fixed-point multiply. Depends on igrl_pkg.
module igrl_alu (
  input  logic [2:0]                    op,
  input  logic signed [igrl_pkg::DW-1:0] a,
  input  logic signed [igrl_pkg::DW-1:0] b,
  output logic signed [igrl_pkg::DW-1:0] y
);

  logic signed [2*igrl_pkg::DW-1:0] prod;
  logic signed [2*igrl_pkg::DW-1:0] shifted;
  logic signed [igrl_pkg::DW:0]     sum;

  // Product with round-half-up, floor shift, then saturate
  assign prod    = a * b + ((2*igrl_pkg::DW)'(1) <<< (igrl_pkg::FRAC_BITS - 1));
  assign shifted = prod >>> igrl_pkg::FRAC_BITS;

  always_comb begin
    case (op)
      igrl_pkg::OP_ADD: sum = {a[igrl_pkg::DW-1], a} + {b[igrl_pkg::DW-1], b};
      igrl_pkg::OP_SUB: sum = {a[igrl_pkg::DW-1], a} - {b[igrl_pkg::DW-1], b};
      igrl_pkg::OP_NEG: sum = -{a[igrl_pkg::DW-1], a};
      default:          sum = '0;
    endcase
  end

  always_comb begin
    if (op == igrl_pkg::OP_MUL) begin
      if (shifted > $signed({{igrl_pkg::DW{1'b0}}, igrl_pkg::Q_MAX})) begin
        y = igrl_pkg::Q_MAX;
      end else if (shifted < $signed({{igrl_pkg::DW{1'b1}}, igrl_pkg::Q_MIN})) begin
        y = igrl_pkg::Q_MIN;
      end else begin
        y = shifted[igrl_pkg::DW-1:0];
      end
    end else begin
      y = igrl_pkg::sat33(sum);
    end
  end

endmodule

FILE: hw/rtl/igrl_div.sv
// Radix-2 restoring divider for rounded, saturating fixed-point quotients.
// One quotient bit per cycle. Depends on igrl_pkg.
module igrl_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [igrl_pkg::DW-1:0] a,
  input  logic signed [igrl_pkg::DW-1:0] b,
  output logic                           done,
  output logic signed [igrl_pkg::DW-1:0] res
);

  localparam int NW = igrl_pkg::DIV_NW;
  localparam int CW = $clog2(NW + 1);

  localparam logic [1:0] DV_IDLE = 2'd0;
  localparam logic [1:0] DV_RUN  = 2'd1;
  localparam logic [1:0] DV_END  = 2'd2;

  logic [1:0]               state;
  logic [CW-1:0]            cnt;
  logic [NW-1:0]            num;
  logic [NW-1:0]            quo;
  logic [igrl_pkg::DW-1:0]  rem;
  logic [igrl_pkg::DW-1:0]  div;
  logic                     neg;
  logic [igrl_pkg::DW-1:0]  ua;
  logic [igrl_pkg::DW-1:0]  ub;
  logic [igrl_pkg::DW:0]    trial;
  logic                     qbit;

  assign ua    = a[igrl_pkg::DW-1] ? igrl_pkg::DW'(-a) : igrl_pkg::DW'(a);
  assign ub    = b[igrl_pkg::DW-1] ? igrl_pkg::DW'(-b) : igrl_pkg::DW'(b);
  assign trial = {rem, num[NW-1]};
  assign qbit  = trial >= {1'b0, div};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        DV_IDLE: begin
          if (start) begin
            neg <= a[igrl_pkg::DW-1] != b[igrl_pkg::DW-1];
            // zero divisor saturates by the sign of the dividend, or gives zero for a zero dividend
            if (ub == '0) begin
              if (a == '0) begin
                res <= '0;
              end else if (a[igrl_pkg::DW-1]) begin
                res <= igrl_pkg::Q_MIN;
              end else begin
                res <= igrl_pkg::Q_MAX;
              end
              done <= 1'b1;
            end else begin
              num   <= (NW'(ua) << igrl_pkg::FRAC_BITS) + NW'(ub >> 1);
              div   <= ub;
              rem   <= '0;
              quo   <= '0;
              cnt   <= '0;
              state <= DV_RUN;
            end
          end
        end
        DV_RUN: begin
          rem <= qbit ? igrl_pkg::DW'(trial - {1'b0, div}) : trial[igrl_pkg::DW-1:0];
          quo <= {quo[NW-2:0], qbit};
          num <= {num[NW-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == CW'(NW - 1)) begin
            state <= DV_END;
          end
        end
        DV_END: begin
          // apply sign and saturate
          if (neg) begin
            if (quo > NW'({1'b1, {(igrl_pkg::DW-1){1'b0}}})) begin
              res <= igrl_pkg::Q_MIN;
            end else begin
              res <= -$signed(quo[igrl_pkg::DW-1:0]);
            end
          end else begin
            if (quo > NW'(igrl_pkg::Q_MAX)) begin
              res <= igrl_pkg::Q_MAX;
            end else begin
              res <= quo[igrl_pkg::DW-1:0];
            end
          end
          done  <= 1'b1;
          state <= DV_IDLE;
        end
        default: state <= DV_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/igrl_checker.sv
// Port-level checks for ibvs_gimbal_rate_law_top, bound to every instance.
// Depends on ibvs_gimbal_rate_law_top's ports and igrl_pkg.
module igrl_checker (
  input logic               clk,
  input logic               rst,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [2:0]         cfg_index,
  input logic [31:0]        cfg_data,
  input logic               in_valid,
  input logic               in_ready,
  input logic               kind,
  input logic signed [31:0] word_a,
  input logic signed [31:0] word_b,
  input logic signed [31:0] word_c,
  input logic signed [31:0] word_d,
  input logic signed [31:0] word_e,
  input logic signed [31:0] word_f,
  input logic signed [17:0] word_g,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] pitch_rate,
  input logic signed [31:0] yaw_rate,
  input logic [1:0]         pitch_limit,
  input logic [1:0]         yaw_limit
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pitch_rate) && $stable(yaw_rate))
    else $error("result changed while stalled");

  // A kind-1 transaction keeps the block busy for the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind |=> !in_ready)
    else $error("ready after a command transaction");

  // Limiter codes stay within passed, clamped and dead zone
  a_codes: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      (pitch_limit == igrl_pkg::LIM_PASS || pitch_limit == igrl_pkg::LIM_CLAMP ||
       pitch_limit == igrl_pkg::LIM_DEAD) &&
      (yaw_limit == igrl_pkg::LIM_PASS || yaw_limit == igrl_pkg::LIM_CLAMP ||
       yaw_limit == igrl_pkg::LIM_DEAD))
    else $error("unknown limiter code");

  // Dead-zone code means a zero rate
  a_dead: assert property (@(posedge clk) disable iff (rst)
    out_valid && (pitch_limit == igrl_pkg::LIM_DEAD || yaw_limit == igrl_pkg::LIM_DEAD) |->
      (pitch_limit != igrl_pkg::LIM_DEAD || pitch_rate == 32'sd0) &&
      (yaw_limit != igrl_pkg::LIM_DEAD || yaw_rate == 32'sd0))
    else $error("dead-zone rate not zero");

endmodule

bind ibvs_gimbal_rate_law_top igrl_checker u_igrl_checker (.*);

FILE: dv/ibvs_gimbal_rate_law_top_test.sv
// Self-checking testbench for ibvs_gimbal_rate_law_top: drives motion and feature
// transactions, predicts rate commands in fixed point and checks each result.
// Depends on igrl_pkg and the RTL of the rate law.
`timescale 1ns / 1ps

module ibvs_gimbal_rate_law_top_test;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] wa, wb, wc, wd, we, wf;
    logic signed [17:0] wg;
  } servo_item_t;

  typedef struct packed {
    logic signed [31:0] pitch, yaw;
    logic [1:0]         pcode, ycode;
  } rate_cmd_t;

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_ready;
  logic kind;
  logic signed [31:0] word_a, word_b, word_c, word_d, word_e, word_f;
  logic signed [17:0] word_g;
  logic out_valid, out_ready;
  logic signed [31:0] pitch_rate, yaw_rate;
  logic [1:0] pitch_limit, yaw_limit;

  ibvs_gimbal_rate_law_top dut (.*);

  // Model state and configuration
  logic [1:0]         m_mode;
  logic [30:0]        m_gain, m_max, m_dead;
  logic signed [31:0] m_tx, m_ty;
  logic signed [31:0] m_motion [6];
  logic signed [31:0] m_tilt;

  servo_item_t pending_items [$];
  rate_cmd_t   expected_cmds [$];
  int errors = 0;
  int cmds_seen = 0;
  int stall_hold = 0;
  int stall_fired = 0;
  logic stall_go = 1'b0;
  int sender_gap = 0;
  int receiver_gap = 0;
  logic in_taken;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return igrl_pkg::Q_MAX;
    if (v < -64'sd2147483648) return igrl_pkg::Q_MIN;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fadd(input logic signed [31:0] a, b);
    return sat64(64'(a) + 64'(b));
  endfunction

  function automatic logic signed [31:0] fsub(input logic signed [31:0] a, b);
    return sat64(64'(a) - 64'(b));
  endfunction

  function automatic logic signed [31:0] fneg(input logic signed [31:0] a);
    return sat64(-64'(a));
  endfunction

  // Rounded product; arithmetic shift is floor
  function automatic logic signed [31:0] fmul(input logic signed [31:0] a, b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd32768;
    return sat64(p >>> 16);
  endfunction

  // Rounded magnitude quotient with sign restored
  function automatic logic signed [31:0] fdiv(input logic signed [31:0] a, b);
    logic [63:0] ua, ub, q;
    logic neg;
    ua = a < 0 ? 64'(-64'(a)) : 64'(a);
    ub = b < 0 ? 64'(-64'(b)) : 64'(b);
    neg = (a < 0) != (b < 0);
    if (ub == 0) begin
      if (a == 0) return 0;
      return a > 0 ? igrl_pkg::Q_MAX : igrl_pkg::Q_MIN;
    end
    q = ((ua << 16) + ub / 2) / ub;
    if (neg) begin
      if (q > 64'h80000000) return igrl_pkg::Q_MIN;
      return sat64(-$signed(q));
    end
    if (q > 64'h7fffffff) return igrl_pkg::Q_MAX;
    return q[31:0];
  endfunction

  function automatic logic signed [31:0] clip(input logic signed [31:0] v,
                                               output logic [1:0] code);
    logic [32:0] mag;
    mag = v < 0 ? 33'(-64'(v)) : 33'(v);
    code = igrl_pkg::LIM_PASS;
    if (mag > {2'b0, m_max}) begin
      v = v < 0 ? -$signed({1'b0, m_max}) : $signed({1'b0, m_max});
      mag = {2'b0, m_max};
      code = igrl_pkg::LIM_CLAMP;
    end
    if (mag < {2'b0, m_dead}) begin
      v = 0;
      code = igrl_pkg::LIM_DEAD;
    end
    return v;
  endfunction

  // Work out the command for one feature transaction, or store motion
  task automatic predict_rates(input servo_item_t it);
    logic signed [31:0] one, x, y, z, px, py, pz, xx, yy, xy, pyz, pxz;
    logic signed [31:0] u0, u1, a0, a1, det, c1, p, yw;
    logic signed [31:0] r0 [6];
    logic signed [31:0] r1 [6];
    rate_cmd_t c;
    one = igrl_pkg::Q_ONE;
    if (!it.kind) begin
      m_motion[0] = it.wa; m_motion[1] = it.wb; m_motion[2] = it.wc;
      m_motion[3] = it.wd; m_motion[4] = it.we; m_motion[5] = it.wf;
      m_tilt = 32'(it.wg);
      return;
    end
    p = 0;
    yw = 0;
    if (m_mode == igrl_pkg::MODE_NORMAL || m_mode == igrl_pkg::MODE_MINUS) begin
      x = it.wa; y = it.wb; z = it.wc; px = it.wd; py = it.we; pz = it.wf;
      xx = fmul(x, x); yy = fmul(y, y); xy = fmul(x, y);
      pyz = fmul(py, z); pxz = fmul(px, z);
      r0[0] = fneg(z);
      r0[1] = 0;
      r0[2] = fmul(x, z);
      r0[3] = fmul(x, fadd(y, pyz));
      r0[4] = fneg(fadd(fadd(one, xx), fmul(z, fadd(pz, fmul(px, x)))));
      r0[5] = fadd(y, pyz);
      r1[0] = 0;
      r1[1] = fneg(z);
      r1[2] = fmul(y, z);
      r1[3] = fadd(fadd(one, yy), fmul(z, fadd(pz, fmul(py, y))));
      r1[4] = fneg(fmul(y, fadd(x, pxz)));
      r1[5] = fsub(fneg(x), pxz);
      u0 = 0;
      u1 = 0;
      for (int i = 0; i < 6; i++) begin
        u0 = fadd(u0, fmul(r0[i], m_motion[i]));
        u1 = fadd(u1, fmul(r1[i], m_motion[i]));
      end
      if (m_mode == igrl_pkg::MODE_NORMAL) begin
        u0 = fadd(u0, fmul($signed({1'b0, m_gain}), fsub(x, m_tx)));
        u1 = fadd(u1, fmul($signed({1'b0, m_gain}), fsub(y, m_ty)));
      end
      a0 = fadd(fmul(fneg(xy), u0), fmul(fadd(one, xx), u1));
      a1 = fadd(fmul(fneg(fadd(one, yy)), u0), fmul(xy, u1));
      det = fadd(fadd(one, xx), yy);
      p = fneg(fdiv(a0, det));
      c1 = fneg(fdiv(a1, det));
      yw = fdiv(c1, m_tilt);
    end
    c.pitch = clip(p, c.pcode);
    c.yaw = clip(yw, c.ycode);
    expected_cmds.push_back(c);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 131071)) - 32'sd65536;
      2: return $signed($urandom_range(0, 1023)) - 32'sd512;
      3: return $signed($urandom_range(0, 16383)) - 32'sd8192;
      4: return $urandom_range(0, 1) ? igrl_pkg::Q_MAX : igrl_pkg::Q_MIN;
      default: return $signed($urandom_range(0, 8388607)) - 32'sd4194304;
    endcase
  endfunction

  function automatic servo_item_t rand_item(input logic k);
    servo_item_t it;
    it.kind = k;
    it.wa = rand_word(); it.wb = rand_word(); it.wc = rand_word();
    it.wd = rand_word(); it.we = rand_word(); it.wf = rand_word();
    case ($urandom_range(0, 5))
      0: it.wg = 18'sd0;
      1: it.wg = 18'sd65536;
      2: it.wg = -18'sd65536;
      3: it.wg = 18'($urandom);
      default: it.wg = 18'($signed($urandom_range(0, 131072)) - 32'sd65536);
    endcase
    return it;
  endfunction

  // Sender: offer queued transactions with random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      kind <= 1'b0;
      word_a <= '0; word_b <= '0; word_c <= '0;
      word_d <= '0; word_e <= '0; word_f <= '0;
      word_g <= '0;
      for (int i = 0; i < 6; i++) m_motion[i] = 0;
      m_tilt = igrl_pkg::Q_ONE;
    end else if (in_valid && !in_taken) begin
      // hold until taken
    end else if (sender_gap > 0) begin
      sender_gap <= sender_gap - 1;
      in_valid <= 1'b0;
    end else if (pending_items.size() > 0) begin
      servo_item_t it;
      it = pending_items.pop_front();
      predict_rates(it);
      in_valid <= 1'b1;
      kind <= it.kind;
      word_a <= it.wa; word_b <= it.wb; word_c <= it.wc;
      word_d <= it.wd; word_e <= it.we; word_f <= it.wf;
      word_g <= it.wg;
      sender_gap <= pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Handshake flag of the sender is set on acceptance at the rising edge
  always @(posedge clk) in_taken <= in_valid && in_ready;

  // Count down the long receiver hold-off once requested
  always @(negedge clk) begin
    if (stall_go && stall_fired == 0) begin
      stall_hold <= 2000;
      stall_fired <= 1;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end
  end

  // Receiver back-pressure, with an optional long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_hold > 0) begin
      out_ready <= 1'b0;
    end else if (receiver_gap > 0) begin
      receiver_gap <= receiver_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (out_valid && out_ready) receiver_gap <= pick_gap();
    end
  end

  // Compare each command with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      rate_cmd_t e;
      cmds_seen <= cmds_seen + 1;
      if (expected_cmds.size() == 0) begin
        $error("unexpected command pitch=%0d yaw=%0d", pitch_rate, yaw_rate);
        errors = errors + 1;
      end else begin
        e = expected_cmds.pop_front();
        if (pitch_rate !== e.pitch) begin
          $error("pitch_rate expected %0d got %0d", e.pitch, pitch_rate);
          errors = errors + 1;
        end
        if (yaw_rate !== e.yaw) begin
          $error("yaw_rate expected %0d got %0d", e.yaw, yaw_rate);
          errors = errors + 1;
        end
        if (pitch_limit !== e.pcode) begin
          $error("pitch_limit expected %0d got %0d", e.pcode, pitch_limit);
          errors = errors + 1;
        end
        if (yaw_limit !== e.ycode) begin
          $error("yaw_limit expected %0d got %0d", e.ycode, yaw_limit);
          errors = errors + 1;
        end
      end
    end
  end

  // Write one register while the block is idle and mirror it
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      igrl_pkg::REG_MODE:  m_mode = val[1:0];
      igrl_pkg::REG_GAIN:  m_gain = val[30:0];
      igrl_pkg::REG_MAX:   m_max = val[30:0];
      igrl_pkg::REG_DEAD:  m_dead = val[30:0];
      igrl_pkg::REG_TGT_X: m_tx = val;
      igrl_pkg::REG_TGT_Y: m_ty = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait for all queued transactions to drain, then the worst-case latency
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_cmds.size() > 0)
      @(posedge clk);
    repeat (260) @(posedge clk);
  endtask

  task automatic push_feature(input logic signed [31:0] x, y, z, px, py, pz);
    servo_item_t it;
    it = rand_item(1'b1);
    it.wa = x; it.wb = y; it.wc = z; it.wd = px; it.we = py; it.wf = pz;
    pending_items.push_back(it);
  endtask

  task automatic push_motion(input logic signed [31:0] v, input logic signed [17:0] c);
    servo_item_t it;
    it = '{1'b0, v, -v, v, v >>> 2, -v, v >>> 1, c};
    pending_items.push_back(it);
  endtask

  int phase_items;

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    m_mode = igrl_pkg::MODE_LOCK; m_gain = 31'd65536; m_max = 31'd65536; m_dead = '0;
    m_tx = 0; m_ty = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: lock mode at reset, then each mode, extremes and zero tilt
    push_feature(igrl_pkg::Q_ONE, igrl_pkg::Q_ONE, igrl_pkg::Q_ONE, 0, 0, 0);
    drain();
    write_reg(igrl_pkg::REG_DEAD, 32'd100);
    push_feature(0, 0, 0, 0, 0, 0);
    drain();
    write_reg(igrl_pkg::REG_MODE, 32'(igrl_pkg::MODE_NORMAL));
    write_reg(igrl_pkg::REG_DEAD, 32'd0);
    write_reg(igrl_pkg::REG_MAX, 32'h7fffffff);
    write_reg(igrl_pkg::REG_GAIN, 32'd32768);
    write_reg(igrl_pkg::REG_TGT_X, 32'hfffc0000);
    write_reg(igrl_pkg::REG_TGT_Y, 32'h00020000);
    push_motion(32'sd65536, 18'sd65536);
    push_feature(igrl_pkg::Q_ONE, -igrl_pkg::Q_ONE, igrl_pkg::Q_ONE,
                 32'sd1000, -32'sd1000, 32'sd2000);
    push_feature(igrl_pkg::Q_MAX, igrl_pkg::Q_MIN, igrl_pkg::Q_MAX,
                 igrl_pkg::Q_MIN, igrl_pkg::Q_MAX, igrl_pkg::Q_MIN);
    push_feature(igrl_pkg::Q_MIN, igrl_pkg::Q_MAX, igrl_pkg::Q_MIN,
                 igrl_pkg::Q_MAX, igrl_pkg::Q_MIN, igrl_pkg::Q_MAX);
    push_feature(0, 0, 0, 0, 0, 0);
    push_motion(32'sd200000, 18'sd0);
    push_feature(igrl_pkg::Q_ONE, igrl_pkg::Q_ONE, igrl_pkg::Q_ONE, 0, 0, 0);
    push_feature(0, 0, 0, 0, 0, 0);
    push_motion(igrl_pkg::Q_MIN, -18'sd65536);
    push_feature(32'sd30000, -32'sd20000, igrl_pkg::Q_ONE, 32'sd5, 32'sd7, -32'sd9);
    push_motion(-32'sd70000, 18'sh20000);
    push_feature(32'sd30000, 32'sd20000, igrl_pkg::Q_ONE, 0, 0, 0);
    drain();
    write_reg(igrl_pkg::REG_MODE, 32'(igrl_pkg::MODE_MINUS));
    write_reg(igrl_pkg::REG_MAX, 32'd1000);
    write_reg(igrl_pkg::REG_DEAD, 32'd500);
    push_motion(32'sd65536, 18'sd40000);
    push_feature(igrl_pkg::Q_ONE, igrl_pkg::Q_ONE, igrl_pkg::Q_ONE, 0, 0, 0);
    push_feature(32'sd100, 32'sd100, 32'sd10, 0, 0, 0);
    drain();
    write_reg(igrl_pkg::REG_MODE, 32'd3);
    push_feature(igrl_pkg::Q_ONE, igrl_pkg::Q_ONE, igrl_pkg::Q_ONE, 0, 0, 0);
    drain();

    // Random phases, each under a fresh configuration
    for (int ph = 0; ph < 9; ph++) begin
      write_reg(igrl_pkg::REG_MODE, (ph % 4 == 3) ? 32'(igrl_pkg::MODE_LOCK) :
                (ph % 2 == 0) ? 32'(igrl_pkg::MODE_NORMAL) : 32'(igrl_pkg::MODE_MINUS));
      write_reg(igrl_pkg::REG_GAIN, ph == 0 ? 32'h7fffffff : ph == 1 ? 32'd0 :
                32'($urandom_range(0, 262144)));
      write_reg(igrl_pkg::REG_MAX, ph == 2 ? 32'd0 : ph == 3 ? 32'h7fffffff :
                32'($urandom_range(1000, 400000)));
      write_reg(igrl_pkg::REG_DEAD, ph == 4 ? 32'h7fffffff : ph == 5 ? 32'd0 :
                32'($urandom_range(0, 3000)));
      write_reg(igrl_pkg::REG_TGT_X, ph == 6 ? 32'h80000000 : 32'(rand_word()));
      write_reg(igrl_pkg::REG_TGT_Y, ph == 6 ? 32'h7fffffff : 32'(rand_word()));
      phase_items = 150;
      for (int n = 0; n < phase_items; n++)
        pending_items.push_back(rand_item($urandom_range(0, 99) < 60));
      // Hold the receiver off long enough for the input to stall
      if (ph == 1) stall_go = 1'b1;
      drain();
    end

    $display("run covered %0d commands over lock, normal and minus tracking,", cmds_seen);
    $display("limiter extremes, zero tilt and receiver back-pressure");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/igrl_pkg.sv
hw/rtl/igrl_alu.sv
hw/rtl/igrl_div.sv
hw/rtl/ibvs_gimbal_rate_law_top.sv
hw/rtl/igrl_checker.sv
dv/ibvs_gimbal_rate_law_top_test.sv
